[sv/length_prefixed_frame_deframer_unit_defines.svh]
// Assertion macros for the deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LPFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define LPFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/lpfd_pkg.sv]
package lpfd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int LEN_W        = 24;

  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_SMALL = 2'd1;
  localparam logic [1:0] STATUS_LARGE = 2'd2;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd4088;

  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_ERROR  = 2'd2
  } cmd_kind_t;

  // first byte to send sits in bytes[31:24]
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] bytes;
    logic        last;
    logic [1:0]  status;
  } cmd_t;

endpackage

[sv/length_prefixed_frame_deframer_unit.sv]
// Length-prefixed deframer: takes one stream byte per cycle whenever full is
// low and cuts the stream into frames with a 4-byte header whose bytes 1..3
// give the big-endian total length. A good header leaves as four result bytes,
// then each frame byte leaves on its own with the last one marked by
// frame_last. A length of 4 or less, or at or above max_frame_bytes, yields a
// single result with a nonzero status, after which every byte is taken and
// dropped until rst. Input moves one transfer per cycle while full is low,
// output one per cycle while pop is high and empty low; the front stage decides
// a byte in the cycle it arrives, and a QUEUE_DEPTH-entry command queue feeds
// the output stage, which sends a header as four result bytes. Full rises when
// that queue fills, behind a stalled pop or while a header is being sent.
// Write max_frame_bytes only while the block is idle.
`include "length_prefixed_frame_deframer_unit_defines.svh"

module length_prefixed_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_byte,
  output logic        frame_last,
  output logic [1:0]  status,
  output logic        empty,
  input  logic        pop,
  input  logic        max_frame_bytes_we,
  input  logic [23:0] max_frame_bytes
);
  import lpfd_pkg::*;

  cmd_t front_cmd;
  cmd_t q_data;
  logic front_push;
  logic q_empty;
  logic q_full;
  logic q_pop;
  logic stuck;
  logic accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  lpfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cfg_we    (max_frame_bytes_we),
    .cfg_data  (max_frame_bytes),
    .cmd_push  (front_push),
    .cmd       (front_cmd),
    .stuck     (stuck)
  );

  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  lpfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_byte   (out_byte),
    .frame_last (frame_last),
    .status     (status),
    .empty      (empty),
    .pop        (pop)
  );

  `LPFD_ASSERT_IMPL(a_no_push_when_full, clk, rst, front_push, !q_full)
  `LPFD_ASSERT_IMPL(a_error_result_clean, clk, rst, !empty && status != STATUS_DATA, out_byte == 8'h0 && !frame_last)
  `LPFD_ASSERT_NEXT(a_error_sticks, clk, rst, stuck, stuck && !front_push)
  `LPFD_ASSERT_IMPL(a_pop_has_data, clk, rst, q_pop, !q_empty)

endmodule

[sv/lpfd_front.sv]
module lpfd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   cfg_we,
  input  logic [23:0]            cfg_data,
  output logic                   cmd_push,
  output lpfd_pkg::cmd_t         cmd,
  output logic                   stuck
);
  import lpfd_pkg::*;

  logic [7:0]       header_bytes [HEADER_BYTES-1];
  logic [1:0]       header_count;
  logic [LEN_W-1:0] frame_length;
  logic [LEN_W-1:0] bytes_seen;
  logic [LEN_W-1:0] max_len;
  logic             error_stuck;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] seen_inc;
  logic             in_frame;
  logic             hdr_done;
  logic             too_small;
  logic             too_large;
  logic             take;

  assign len       = {header_bytes[1], header_bytes[2], data_byte};
  assign seen_inc  = bytes_seen + LEN_W'(1);
  assign in_frame  = frame_length != '0;
  assign hdr_done  = header_count == 2'(HEADER_BYTES - 1);
  assign too_small = len <= LEN_W'(HEADER_BYTES);
  assign too_large = len >= max_len;
  assign take      = accept && !error_stuck;
  assign stuck     = error_stuck;

  always_comb begin
    cmd_push   = 1'b0;
    cmd.kind   = CMD_DATA;
    cmd.bytes  = {data_byte, 24'h0};
    cmd.last   = 1'b0;
    cmd.status = STATUS_DATA;
    if (take) begin
      if (in_frame) begin
        cmd_push = 1'b1;
        cmd.last = seen_inc >= frame_length;
      end else if (hdr_done) begin
        cmd_push = 1'b1;
        if (too_small) begin
          cmd.kind   = CMD_ERROR;
          cmd.bytes  = '0;
          cmd.status = STATUS_SMALL;
        end else if (too_large) begin
          cmd.kind   = CMD_ERROR;
          cmd.bytes  = '0;
          cmd.status = STATUS_LARGE;
        end else begin
          cmd.kind  = CMD_HEADER;
          cmd.bytes = {header_bytes[0], header_bytes[1], header_bytes[2], data_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !in_frame && !hdr_done) begin
      header_bytes[header_count] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
      error_stuck  <= 1'b0;
    end else if (take) begin
      if (in_frame) begin
        if (seen_inc >= frame_length) begin
          frame_length <= '0;
          bytes_seen   <= '0;
        end else begin
          bytes_seen <= seen_inc;
        end
      end else if (hdr_done) begin
        header_count <= '0;
        if (too_small || too_large) begin
          error_stuck <= 1'b1;
        end else begin
          frame_length <= len;
          bytes_seen   <= LEN_W'(HEADER_BYTES);
        end
      end else begin
        header_count <= header_count + 2'd1;
      end
    end
  end

endmodule

[sv/lpfd_queue.sv]
module lpfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  lpfd_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output lpfd_pkg::cmd_t rd_data,
  output logic           q_empty,
  output logic           q_full
);
  import lpfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_empty = count == '0;
  assign q_full  = count == CNT_W'(DEPTH);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[sv/lpfd_back.sv]
module lpfd_back (
  input  logic           clk,
  input  logic           rst,
  input  lpfd_pkg::cmd_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  output logic [7:0]     out_byte,
  output logic           frame_last,
  output logic [1:0]     status,
  output logic           empty,
  input  logic           pop
);
  import lpfd_pkg::*;

  logic        out_valid;
  logic [23:0] hdr_rest;
  logic [1:0]  hdr_left;
  logic        load;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_pop = load && (hdr_left == '0) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_left  <= '0;
    end else if (load) begin
      if (hdr_left != '0) begin
        out_valid  <= 1'b1;
        out_byte   <= hdr_rest[23:16];
        frame_last <= 1'b0;
        status     <= STATUS_DATA;
        hdr_rest   <= {hdr_rest[15:0], 8'h0};
        hdr_left   <= hdr_left - 2'd1;
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        out_byte   <= q_data.bytes[31:24];
        frame_last <= q_data.last;
        status     <= q_data.status;
        if (q_data.kind == CMD_HEADER) begin
          hdr_rest <= q_data.bytes[23:0];
          hdr_left <= 2'(HEADER_BYTES - 1);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[verif/deframer_checker.sv]
`timescale 1ns / 1ps

module deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  out_byte,
  input  logic        frame_last,
  input  logic [1:0]  status,
  input  logic        empty,
  input  logic        pop,
  input  logic        max_frame_bytes_we,
  input  logic [23:0] max_frame_bytes,
  output int          fail_count,
  output int          outstanding,
  output int          bytes_taken,
  output int          results_taken,
  output int          frames_closed
);
  import lpfd_pkg::*;

  typedef struct packed {
    logic [7:0] octet;
    logic       ends_frame;
    logic [1:0] code;
  } frame_out_t;

  frame_out_t       due_results[$];
  logic [LEN_W-1:0] len_limit;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] frame_pos;
  logic [7:0]       hdr[HEADER_BYTES];
  int               hdr_fill;
  logic             closed;

  function automatic void deframe_byte(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    if (closed) return;
    if (cur_len == '0) begin
      hdr[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill < HEADER_BYTES) return;
      hdr_fill = 0;
      len = {hdr[1], hdr[2], hdr[3]};
      if (len <= HEADER_BYTES) begin
        closed = 1'b1;
        due_results.push_back('{octet: 8'h00, ends_frame: 1'b0, code: STATUS_SMALL});
      end else if (len >= len_limit) begin
        closed = 1'b1;
        due_results.push_back('{octet: 8'h00, ends_frame: 1'b0, code: STATUS_LARGE});
      end else begin
        cur_len = len;
        frame_pos = HEADER_BYTES;
        for (int k = 0; k < HEADER_BYTES; k++)
          due_results.push_back('{octet: hdr[k], ends_frame: 1'b0, code: STATUS_DATA});
      end
    end else begin
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= cur_len) begin
        due_results.push_back('{octet: b, ends_frame: 1'b1, code: STATUS_DATA});
        cur_len = '0;
        frame_pos = '0;
        frames_closed++;
      end else begin
        due_results.push_back('{octet: b, ends_frame: 1'b0, code: STATUS_DATA});
      end
    end
  endfunction

  always @(posedge clk) begin
    frame_out_t want;
    if (rst) begin
      due_results.delete();
      len_limit = MAX_LEN_RESET;
      cur_len = '0;
      frame_pos = '0;
      hdr_fill = 0;
      closed = 1'b0;
      for (int k = 0; k < HEADER_BYTES; k++) hdr[k] = 8'h00;
      fail_count = 0;
      bytes_taken = 0;
      results_taken = 0;
      frames_closed = 0;
    end else begin
      if (max_frame_bytes_we) len_limit = max_frame_bytes;
      if (pop && !empty) begin
        results_taken++;
        if (due_results.size() == 0) begin
          $error("result with nothing due: out_byte %02h frame_last %0d status %0d",
                 out_byte, frame_last, status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_byte !== want.octet) begin
            $error("out_byte: expected %02h, got %02h", want.octet, out_byte);
            fail_count++;
          end
          if (frame_last !== want.ends_frame) begin
            $error("frame_last: expected %0d, got %0d", want.ends_frame, frame_last);
            fail_count++;
          end
          if (status !== want.code) begin
            $error("status: expected %0d, got %0d", want.code, status);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        bytes_taken++;
        deframe_byte(data_byte);
      end
    end
    outstanding = due_results.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lpfd_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_BYTES = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  data_byte;
  logic        push;
  logic        full;
  logic [7:0]  out_byte;
  logic        frame_last;
  logic [1:0]  status;
  logic        empty;
  logic        pop;
  logic        max_frame_bytes_we;
  logic [23:0] max_frame_bytes;

  int fail_count;
  int outstanding;
  int bytes_taken;
  int results_taken;
  int frames_closed;

  logic [7:0] stream_q[$];
  int         burst_left = 4;
  int         gap_left = 0;
  int         hold_cycles = 0;
  int         pat_mode = 0;
  int         pat_left = 0;
  int         stall_cycles = 0;
  int         limits_used = 0;

  length_prefixed_frame_deframer_unit i_dut (
    .clk                (clk),
    .rst                (rst),
    .data_byte          (data_byte),
    .push               (push),
    .full               (full),
    .out_byte           (out_byte),
    .frame_last         (frame_last),
    .status             (status),
    .empty              (empty),
    .pop                (pop),
    .max_frame_bytes_we (max_frame_bytes_we),
    .max_frame_bytes    (max_frame_bytes)
  );

  deframer_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .data_byte          (data_byte),
    .push               (push),
    .full               (full),
    .out_byte           (out_byte),
    .frame_last         (frame_last),
    .status             (status),
    .empty              (empty),
    .pop                (pop),
    .max_frame_bytes_we (max_frame_bytes_we),
    .max_frame_bytes    (max_frame_bytes),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .bytes_taken        (bytes_taken),
    .results_taken      (results_taken),
    .frames_closed      (frames_closed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sender: bursts of random length, random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      data_byte <= 8'h00;
    end else begin
      if (push && !full) begin
        stream_q.delete(0);
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!(push && full)) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (stream_q.size() != 0) begin
          push <= 1'b1;
          data_byte <= stream_q[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: switches between stall patterns, honors long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(8, 40);
      end
      pat_left--;
      case (pat_mode)
        0: begin
          pop <= 1'b1;
        end
        1: begin
          pop <= 1'($urandom_range(0, 1));
        end
        2: begin
          pop <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          pop <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_header(input logic [7:0] lead, input logic [LEN_W-1:0] len);
    stream_q.push_back(lead);
    stream_q.push_back(len[23:16]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
  endtask

  task automatic queue_frame(input logic [LEN_W-1:0] len);
    queue_header(8'($urandom), len);
    for (int k = HEADER_BYTES; k < len; k++) stream_q.push_back(8'($urandom));
  endtask

  task automatic settle();
    do @(negedge clk); while (stream_q.size() != 0 || push || outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_len_limit(input logic [LEN_W-1:0] value);
    @(posedge clk);
    max_frame_bytes_we <= 1'b1;
    max_frame_bytes <= value;
    @(posedge clk);
    max_frame_bytes_we <= 1'b0;
    limits_used++;
  endtask

  task automatic run_frames(input logic [LEN_W-1:0] limit, input bit squeeze);
    int queued;
    int cap;
    int len;
    queued = 0;
    while (queued < PHASE_BYTES) begin
      cap = (limit - 1 > 40) ? 40 : limit - 1;
      if ($urandom_range(0, 9) == 0 && limit - 1 > 40)
        cap = (limit - 1 > 300) ? 300 : limit - 1;
      len = $urandom_range(HEADER_BYTES + 1, cap);
      if ($urandom_range(0, 7) == 0 && limit - 1 <= 300) len = limit - 1;
      queue_frame(LEN_W'(len));
      queued += len;
    end
    if (squeeze) begin
      @(negedge clk);
      hold_cycles = 80;
    end
    settle();
  endtask

  initial begin
    logic [LEN_W-1:0] limits[5];
    logic [LEN_W-1:0] cur_limit;
    logic [LEN_W-1:0] bad_len;
    int squeeze_phase;
    int close_kind;
    string close_name;

    max_frame_bytes_we <= 1'b0;
    max_frame_bytes <= 24'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset length limit
    queue_header(8'h00, 24'd5);
    stream_q.push_back(8'hFF);
    queue_header(8'hFF, 24'd6);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    queue_header(8'h5A, 24'd12);
    for (int k = 0; k < 8; k++) stream_q.push_back(k[0] ? 8'hAA : 8'h55);
    settle();

    limits[0] = 24'd6;
    limits[1] = 24'hFFFFFF;
    limits[2] = LEN_W'($urandom_range(7, 48));
    limits[3] = LEN_W'($urandom_range(49, 400));
    limits[4] = MAX_LEN_RESET;
    squeeze_phase = $urandom_range(0, 4);
    for (int p = 0; p < 5; p++) begin
      set_len_limit(limits[p]);
      run_frames(limits[p], p == squeeze_phase);
    end

    // close the stream with one bad header, then feed bytes that get dropped
    close_kind = $urandom_range(0, 2);
    case (close_kind)
      0: begin
        close_name = "too-short";
        bad_len = LEN_W'($urandom_range(0, HEADER_BYTES));
      end
      1: begin
        close_name = "too-long";
        cur_limit = LEN_W'(($urandom_range(0, 1) == 0) ? 24'hFFFFFF
                                                       : $urandom_range(6, 24'hFFFFFF));
        set_len_limit(cur_limit);
        bad_len = LEN_W'($urandom_range(cur_limit, 24'hFFFFFF));
      end
      default: begin
        close_name = "too-short and too-long";
        cur_limit = LEN_W'($urandom_range(0, HEADER_BYTES));
        set_len_limit(cur_limit);
        bad_len = LEN_W'($urandom_range(cur_limit, HEADER_BYTES));
      end
    endcase
    queue_header(8'($urandom), bad_len);
    queue_header(8'h00, 24'd5);
    stream_q.push_back(8'($urandom));
    for (int k = 0; k < 10; k++) stream_q.push_back(8'($urandom));
    settle();
    repeat (20) @(posedge clk);

    $display("%0d stream bytes in, %0d results out, %0d whole frames, %0d length limits",
             bytes_taken, results_taken, frames_closed, limits_used);
    $display("stream closed by a %s header, later bytes dropped", close_name);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
